// ===== rtl/core/rre_pkg.sv =====
`default_nettype none

package rre_pkg;

  // defaults for the top level parameters
  localparam int COORD_WIDTH_DEF = 16;
  localparam int TRIG_STAGES_DEF = 16;

  // cordic limits and formats
  localparam int CORDIC_MAX = 24;
  localparam int TRIG_W     = 32;
  localparam logic signed [TRIG_W-1:0] X_INIT = 32'sd652032874;

  // extent, product and rounding widths
  localparam int CFG_W     = 16;
  localparam int EXT_W     = 2 * CFG_W;
  localparam int PROD_W    = EXT_W + 1 + TRIG_W;
  localparam int ACC_W     = PROD_W + 1;
  localparam int RND_SHIFT = 43;
  localparam int OFS_W     = ACC_W - RND_SHIFT;
  localparam int ROT_W     = 16;

  // register reset values
  localparam logic [CFG_W-1:0] SCALE_ONE = 16'd4096;

  typedef enum logic [1:0] {
    REG_WIDTH   = 2'd0,
    REG_HEIGHT  = 2'd1,
    REG_SCALE_H = 2'd2,
    REG_SCALE_V = 2'd3
  } cfg_reg_t;

  localparam logic [1:0] EDGE_LAST = 2'd3;

  // atan(2^-i) with 2^32 units per turn
  function automatic logic [TRIG_W-1:0] atan_angle(input int unsigned idx);
    logic [TRIG_W-1:0] a;
    case (idx)
      0:  a = 32'd536870912;
      1:  a = 32'd316933406;
      2:  a = 32'd167458907;
      3:  a = 32'd85004756;
      4:  a = 32'd42667331;
      5:  a = 32'd21354465;
      6:  a = 32'd10679838;
      7:  a = 32'd5340245;
      8:  a = 32'd2670163;
      9:  a = 32'd1335087;
      10: a = 32'd667544;
      11: a = 32'd333772;
      12: a = 32'd166886;
      13: a = 32'd83443;
      14: a = 32'd41722;
      15: a = 32'd20861;
      16: a = 32'd10430;
      17: a = 32'd5215;
      18: a = 32'd2608;
      19: a = 32'd1304;
      20: a = 32'd652;
      21: a = 32'd326;
      22: a = 32'd163;
      23: a = 32'd81;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rre_cordic.sv =====
`default_nettype none

module rre_cordic #(
  parameter int TRIG_STAGES = rre_pkg::TRIG_STAGES_DEF,
  parameter int SIDE_W      = 2 * rre_pkg::COORD_WIDTH_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   en,
  input  wire                                   in_valid,
  input  wire  [rre_pkg::ROT_W-1:0]             in_rotation,
  input  wire  [SIDE_W-1:0]                     in_side,
  output logic                                  out_valid,
  output logic signed [rre_pkg::TRIG_W-1:0]     out_cos,
  output logic signed [rre_pkg::TRIG_W-1:0]     out_sin,
  output logic [SIDE_W-1:0]                     out_side
);
  import rre_pkg::*;

  localparam int N = (TRIG_STAGES > CORDIC_MAX) ? CORDIC_MAX : TRIG_STAGES;
  localparam logic signed [TRIG_W-1:0] QUARTER = 32'sh4000_0000;

  logic signed [TRIG_W-1:0] x    [N+1];
  logic signed [TRIG_W-1:0] y    [N+1];
  logic signed [TRIG_W-1:0] z    [N+1];
  logic                     v    [N+1];
  logic                     flip [N+1];
  logic [SIDE_W-1:0]        side [N+1];

  logic signed [TRIG_W-1:0] z_raw;
  logic signed [TRIG_W-1:0] z_pre;
  logic                     flip_pre;

  // fold into the right half plane; adding a half turn flips the top bit
  assign z_raw    = signed'({in_rotation, {(TRIG_W-ROT_W){1'b0}}});
  assign flip_pre = (z_raw > QUARTER) || (z_raw < -QUARTER);
  assign z_pre    = flip_pre ? (z_raw ^ {1'b1, {(TRIG_W-1){1'b0}}}) : z_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x[0]    <= X_INIT;
      y[0]    <= '0;
      z[0]    <= z_pre;
      flip[0] <= flip_pre;
      side[0] <= in_side;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [TRIG_W-1:0] xs;
    logic signed [TRIG_W-1:0] ys;
    logic signed [TRIG_W-1:0] ang;
    logic                     pos;

    assign xs  = x[i] >>> i;
    assign ys  = y[i] >>> i;
    assign ang = signed'(atan_angle(i));
    assign pos = ~z[i][TRIG_W-1];

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x[i+1]    <= pos ? (x[i] - ys) : (x[i] + ys);
        y[i+1]    <= pos ? (y[i] + xs) : (y[i] - xs);
        z[i+1]    <= pos ? (z[i] - ang) : (z[i] + ang);
        flip[i+1] <= flip[i];
        side[i+1] <= side[i];
      end
    end
  end

  // undo the half turn taken at the front
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_cos  <= flip[N] ? -x[N] : x[N];
      out_sin  <= flip[N] ? -y[N] : y[N];
      out_side <= side[N];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rotated_rectangle_edges.sv =====
`default_nettype none

// channel   dir  tdata (low bit up)                      tuser        tlast
// s_*       in   center_x, center_y, rotation, zero pad  -            -
// m_*       out  start_x, start_y, end_x, end_y, pad     edge_index   last_edge
// cfg_*     in   cfg_index selects, cfg_data low 16 bits written
//
// an item taken passes through the cordic rotator of TRIG_STAGES stages
// (capped at CORDIC_MAX) plus entry, sign, multiply, sum, round and corner
// stages into the edge output sequencer, which sends one edge per cycle
// while m_tready is high and loads the next item as its last edge leaves
// reset clears every valid bit, the sequencer and the size registers and
// sets the scale registers to SCALE_ONE; while the sequencer still holds an
// item and the corner stage is full, the whole pipeline and s_tready hold

module rotated_rectangle_edges #(
  parameter int COORD_WIDTH = rre_pkg::COORD_WIDTH_DEF,
  parameter int TRIG_STAGES = rre_pkg::TRIG_STAGES_DEF,
  parameter int IN_W  = ((2 * COORD_WIDTH + rre_pkg::ROT_W + 7) / 8) * 8,
  parameter int OUT_W = ((4 * COORD_WIDTH + 7) / 8) * 8
) (
  input  wire                          clk,
  input  wire                          rst,
  // center_x, center_y, rotation
  input  wire                          s_tvalid,
  output logic                         s_tready,
  input  wire  [IN_W-1:0]              s_tdata,
  // start_x, start_y, end_x, end_y
  output logic                         m_tvalid,
  input  wire                          m_tready,
  output logic [OUT_W-1:0]             m_tdata,
  // edge_index
  output logic [1:0]                   m_tuser,
  output logic                         m_tlast,
  input  wire                          cfg_we,
  input  rre_pkg::cfg_reg_t            cfg_index,
  input  wire  [rre_pkg::CFG_W-1:0]    cfg_data
);
  import rre_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int SUM_W = ((CW > OFS_W) ? CW : OFS_W) + 1;
  localparam logic signed [SUM_W-1:0] SAT_HI =
    {{(SUM_W-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO =
    {{(SUM_W-CW+1){1'b1}}, {(CW-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(64'd1 << (RND_SHIFT - 1));

  // configuration
  logic [CFG_W-1:0] rect_width;
  logic [CFG_W-1:0] rect_height;
  logic [CFG_W-1:0] scale_horizontal;
  logic [CFG_W-1:0] scale_vertical;
  logic [EXT_W-1:0] ext_w;
  logic [EXT_W-1:0] ext_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      rect_width       <= '0;
      rect_height      <= '0;
      scale_horizontal <= SCALE_ONE;
      scale_vertical   <= SCALE_ONE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:   rect_width       <= cfg_data;
        REG_HEIGHT:  rect_height      <= cfg_data;
        REG_SCALE_H: scale_horizontal <= cfg_data;
        REG_SCALE_V: scale_vertical   <= cfg_data;
        default: ;
      endcase
    end
  end

  // full extents, settled long before an item reaches the multipliers
  always_ff @(posedge clk) begin
    ext_w <= EXT_W'(rect_width) * EXT_W'(scale_horizontal);
    ext_h <= EXT_W'(rect_height) * EXT_W'(scale_vertical);
  end

  // pipeline control
  logic en;
  logic load;
  logic take;
  logic v_t, v_m, v_s, v_r, v_c;

  // cordic
  logic signed [TRIG_W-1:0] cos_t;
  logic signed [TRIG_W-1:0] sin_t;
  logic [2*CW-1:0]          ctr_t;

  assign s_tready = en;

  rre_cordic #(
    .TRIG_STAGES (TRIG_STAGES),
    .SIDE_W      (2 * CW)
  ) u_cordic (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (s_tvalid),
    .in_rotation (s_tdata[2*CW +: ROT_W]),
    .in_side     (s_tdata[2*CW-1:0]),
    .out_valid   (v_t),
    .out_cos     (cos_t),
    .out_sin     (sin_t),
    .out_side    (ctr_t)
  );

  // multiply stage
  logic signed [EXT_W:0]    ew_s;
  logic signed [EXT_W:0]    eh_s;
  logic signed [PROD_W-1:0] pa, pb, pc, pd;
  logic [2*CW-1:0]          ctr_m;

  assign ew_s = signed'({1'b0, ext_w});
  assign eh_s = signed'({1'b0, ext_h});

  always_ff @(posedge clk) begin
    if (en) begin
      pa    <= PROD_W'(ew_s) * PROD_W'(cos_t);
      pb    <= PROD_W'(ew_s) * PROD_W'(sin_t);
      pc    <= PROD_W'(eh_s) * PROD_W'(cos_t);
      pd    <= PROD_W'(eh_s) * PROD_W'(sin_t);
      ctr_m <= ctr_t;
    end
  end

  // sum stage: corner offsets are +-(a +- d) and +-(b +- c)
  logic signed [ACC_W-1:0] sp, sm, sq, sr;
  logic [2*CW-1:0]         ctr_s;

  always_ff @(posedge clk) begin
    if (en) begin
      sp    <= ACC_W'(pa) + ACC_W'(pd);
      sm    <= ACC_W'(pa) - ACC_W'(pd);
      sq    <= ACC_W'(pb) + ACC_W'(pc);
      sr    <= ACC_W'(pb) - ACC_W'(pc);
      ctr_s <= ctr_m;
    end
  end

  // round stage, half up, dropping the doubling with the fraction
  logic signed [ACC_W-1:0] rx [4];
  logic signed [ACC_W-1:0] ry [4];
  logic signed [OFS_W-1:0] ox [4];
  logic signed [OFS_W-1:0] oy [4];
  logic [2*CW-1:0]         ctr_r;

  assign rx[0] = RND_HALF - sm;
  assign ry[0] = RND_HALF - sq;
  assign rx[1] = RND_HALF + sp;
  assign ry[1] = RND_HALF + sr;
  assign rx[2] = RND_HALF + sm;
  assign ry[2] = RND_HALF + sq;
  assign rx[3] = RND_HALF - sp;
  assign ry[3] = RND_HALF - sr;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        ox[k] <= rx[k][ACC_W-1:RND_SHIFT];
        oy[k] <= ry[k][ACC_W-1:RND_SHIFT];
      end
      ctr_r <= ctr_s;
    end
  end

  // corner stage: add center and saturate
  logic signed [CW-1:0]    cx_r, cy_r;
  logic signed [SUM_W-1:0] sum_x [4];
  logic signed [SUM_W-1:0] sum_y [4];
  logic signed [CW-1:0]    sat_x [4];
  logic signed [CW-1:0]    sat_y [4];
  logic signed [CW-1:0]    px [4];
  logic signed [CW-1:0]    py [4];

  assign cx_r = signed'(ctr_r[CW-1:0]);
  assign cy_r = signed'(ctr_r[2*CW-1:CW]);

  for (genvar k = 0; k < 4; k++) begin : g_corner
    assign sum_x[k] = SUM_W'(cx_r) + SUM_W'(ox[k]);
    assign sum_y[k] = SUM_W'(cy_r) + SUM_W'(oy[k]);

    always_comb begin
      if (sum_x[k] > SAT_HI) begin
        sat_x[k] = SAT_HI[CW-1:0];
      end else if (sum_x[k] < SAT_LO) begin
        sat_x[k] = SAT_LO[CW-1:0];
      end else begin
        sat_x[k] = sum_x[k][CW-1:0];
      end
      if (sum_y[k] > SAT_HI) begin
        sat_y[k] = SAT_HI[CW-1:0];
      end else if (sum_y[k] < SAT_LO) begin
        sat_y[k] = SAT_LO[CW-1:0];
      end else begin
        sat_y[k] = sum_y[k][CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        px[k] <= sat_x[k];
        py[k] <= sat_y[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_m <= 1'b0;
      v_s <= 1'b0;
      v_r <= 1'b0;
      v_c <= 1'b0;
    end else if (en) begin
      v_m <= v_t;
      v_s <= v_m;
      v_r <= v_s;
      v_c <= v_r;
    end
  end

  // edge sequencer: holds one rectangle and walks its edges in order
  logic                 out_valid;
  logic [1:0]           edge_cnt;
  logic [1:0]           edge_nxt;
  logic signed [CW-1:0] hx [4];
  logic signed [CW-1:0] hy [4];

  assign take     = out_valid && m_tready;
  assign load     = v_c && (!out_valid || (take && (edge_cnt == EDGE_LAST)));
  assign en       = !v_c || load;
  assign edge_nxt = edge_cnt + 2'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      edge_cnt  <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      edge_cnt  <= '0;
    end else if (take) begin
      if (edge_cnt == EDGE_LAST) begin
        out_valid <= 1'b0;
      end
      edge_cnt <= edge_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int k = 0; k < 4; k++) begin
        hx[k] <= px[k];
        hy[k] <= py[k];
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = edge_cnt;
  assign m_tlast  = (edge_cnt == EDGE_LAST);
  assign m_tdata  = OUT_W'({hy[edge_nxt], hx[edge_nxt], hy[edge_cnt], hx[edge_cnt]});

  // the next edge follows in order straight after a non-final one
  a_edge_step: assert property (@(posedge clk) disable iff (rst)
    take && !m_tlast |=> m_tvalid && (m_tuser == $past(edge_nxt)))
    else $error("edge index did not advance");

  // a waiting rectangle starts at edge zero right after the last edge leaves
  a_back_to_back: assert property (@(posedge clk) disable iff (rst)
    take && m_tlast && v_c |=> m_tvalid && (m_tuser == 2'd0))
    else $error("waiting rectangle not issued");

  // consecutive edges of one rectangle share a corner
  a_shared_corner: assert property (@(posedge clk) disable iff (rst)
    take && !m_tlast |=> (m_tdata[2*CW-1:0] == $past(m_tdata[4*CW-1:2*CW])))
    else $error("edge chain broken");

  // the pipeline only stalls on a full corner stage, which then holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> v_c)
    else $error("corner stage lost while stalled");

endmodule

`default_nettype wire
